/* hdl/phsi_pkg.sv */
// ----------------------------------------------------------------------------
// phsi_pkg: shared definitions for hard-sphere insertion
// Codes, defaults and controller/datapath handshake structures.
// ----------------------------------------------------------------------------
package phsi_pkg;

  // Default sizing
  localparam int PHSI_MAX_PARTICLES = 256;
  localparam int PHSI_COORD_BITS    = 16;

  // Fixed field widths
  localparam int FIELD_W     = 16;
  localparam int STATUS_W    = 2;
  localparam int SLOT_W      = 8;
  localparam int OUT_CNT_W   = 9;
  localparam int CFG_ADDR_W  = 1;

  // Configuration register indexes
  localparam logic [CFG_ADDR_W-1:0] CFG_BOX_LENGTH   = 1'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_MIN_DISTANCE = 1'd1;

  // Register reset values
  localparam logic [FIELD_W-1:0] BOX_LENGTH_RST   = 16'd25998;
  localparam logic [FIELD_W-1:0] MIN_DISTANCE_RST = 16'd4096;

  // Operation codes
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_CLEAR  = 1'b1;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_OVERLAP = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;
  localparam logic [STATUS_W-1:0] ST_OUTSIDE = 2'd3;

  // Controller to datapath
  typedef struct packed {
    logic load;    // latch a new word and restart the scan
    logic issue;   // read the next stored particle
    logic finish;  // commit the outcome and load the output register
  } phsi_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic quick;     // outcome known without a scan
    logic last;      // the current read is the last stored particle
    logic busy;      // compare pipeline still holds reads
    logic hit;       // an overlap has been seen
    logic out_free;  // output register can take a result
  } phsi_sts_t;

endpackage

/* hdl/periodic_hard_sphere_insertion_top.sv */
// ----------------------------------------------------------------------------
// periodic_hard_sphere_insertion_top: hard-sphere insertion with overlap check
// Checks a candidate against every stored particle using minimum-image
// distances in a cubic periodic box and stores it when nothing overlaps.
//
//   Channel | Direction | Payload
//   --------+-----------+----------------------------------------------------
//   in_     | slave     | tuser: op; tdata: cand_x, cand_y, cand_z
//   out_    | master    | tuser: status; tdata: slot, stored_count
//   cfg_    | write     | 0 box_length, 1 min_distance
//
// An insert reads the stored particles one per cycle from the position
// store into a three-stage compare pipeline; a scan stops early once an
// overlap is seen. Clear, outside-box and store-full words skip the scan.
// One word is worked on at a time; the next is accepted while a finished
// result waits in the output register.
// Reset (rst_n low, synchronous) empties the store and restores the
// register defaults; no clearing pass is needed.
// ----------------------------------------------------------------------------
module periodic_hard_sphere_insertion_top import phsi_pkg::*; #(
  parameter int MAX_PARTICLES = PHSI_MAX_PARTICLES,
  parameter int COORD_BITS    = PHSI_COORD_BITS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [FIELD_W-1:0]    cfg_wdata,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [3*FIELD_W-1:0]  in_tdata,   // cand_x, cand_y, cand_z
  input  logic                  in_tuser,   // op
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [23:0]           out_tdata,  // slot, stored_count, zero fill
  output logic [STATUS_W-1:0]   out_tuser   // status
);

  phsi_cmd_t cmd;
  phsi_sts_t sts;

  logic [SLOT_W-1:0]    slot;
  logic [OUT_CNT_W-1:0] stored_count;

  phsi_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  phsi_dp #(
    .MAX_PARTICLES (MAX_PARTICLES),
    .COORD_BITS    (COORD_BITS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_op      (in_tuser),
    .in_cand_x  (in_tdata[FIELD_W-1:0]),
    .in_cand_y  (in_tdata[2*FIELD_W-1:FIELD_W]),
    .in_cand_z  (in_tdata[3*FIELD_W-1:2*FIELD_W]),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_status (out_tuser),
    .out_slot   (slot),
    .out_count  (stored_count),
    .cmd        (cmd),
    .sts        (sts)
  );

  assign out_tdata = {7'd0, stored_count, slot};

endmodule

/* hdl/phsi_ctrl.sv */
// ----------------------------------------------------------------------------
// phsi_ctrl: sequencing controller
// Walks one word through accept, scan of the store, drain and result.
// ----------------------------------------------------------------------------
module phsi_ctrl import phsi_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_tvalid,
  output logic      in_tready,
  input  phsi_sts_t sts,
  output phsi_cmd_t cmd
);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_SCAN   = 4'b0010,
    S_DRAIN  = 4'b0100,
    S_FINISH = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    state_nxt  = state_r;
    cmd.load   = 1'b0;
    cmd.issue  = 1'b0;
    cmd.finish = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        // Stop reading as soon as the outcome or an overlap is known.
        if (sts.quick || sts.hit) begin
          state_nxt = S_FINISH;
        end else begin
          cmd.issue = 1'b1;
          if (sts.last) begin
            state_nxt = S_DRAIN;
          end
        end
      end
      S_DRAIN: begin
        if (!sts.busy || sts.hit) begin
          state_nxt = S_FINISH;
        end
      end
      S_FINISH: begin
        if (sts.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

/* hdl/phsi_dp.sv */
// ----------------------------------------------------------------------------
// phsi_dp: position store and minimum-image compare datapath
// Holds the configuration, the particle store, a three-stage compare
// pipeline (read, square, sum and compare) and the output register.
// ----------------------------------------------------------------------------
module phsi_dp import phsi_pkg::*; #(
  parameter int MAX_PARTICLES = PHSI_MAX_PARTICLES,
  parameter int COORD_BITS    = PHSI_COORD_BITS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [FIELD_W-1:0]    cfg_wdata,
  input  logic                  in_op,
  input  logic [FIELD_W-1:0]    in_cand_x,
  input  logic [FIELD_W-1:0]    in_cand_y,
  input  logic [FIELD_W-1:0]    in_cand_z,
  input  logic                  out_tready,
  output logic                  out_tvalid,
  output logic [STATUS_W-1:0]   out_status,
  output logic [SLOT_W-1:0]     out_slot,
  output logic [OUT_CNT_W-1:0]  out_count,
  input  phsi_cmd_t             cmd,
  output phsi_sts_t             sts
);

  localparam int CW    = COORD_BITS;
  localparam int AW    = (MAX_PARTICLES > 1) ? $clog2(MAX_PARTICLES) : 1;
  localparam int CNT_W = $clog2(MAX_PARTICLES + 1);
  localparam int CMP_W = (CW > FIELD_W) ? CW : FIELD_W;
  localparam int DW    = CMP_W + 2;
  localparam int MAG_W = DW - 1;
  localparam int SQ_W  = 2 * MAG_W;
  localparam int SUM_W = SQ_W + 2;
  localparam int LIM_W = 2 * FIELD_W;

  // Configuration
  logic [FIELD_W-1:0] box_r;
  logic [FIELD_W-1:0] min_r;

  // Current word
  logic          op_r;
  logic          outside_r;
  logic [CW-1:0] cx_r, cy_r, cz_r;
  logic [LIM_W-1:0] limit_r;

  // Store and scan
  logic [3*CW-1:0] pos_mem [MAX_PARTICLES];
  logic [3*CW-1:0] rd_pos_r;
  logic            rd_vld_r;
  logic [AW-1:0]   scan_addr_r;
  logic [CNT_W-1:0] count_r, count_nxt;

  // Compare pipeline
  logic [MAG_W-1:0] mag_x, mag_y, mag_z;
  logic [SQ_W-1:0]  sq_x_r, sq_y_r, sq_z_r;
  logic             sq_vld_r;
  logic [SUM_W-1:0] dist_sq;
  logic             hit_r;

  // Output register
  logic                 out_vld_r;
  logic [STATUS_W-1:0]  out_status_r, out_status_nxt;
  logic [SLOT_W-1:0]    out_slot_r, out_slot_nxt;
  logic [OUT_CNT_W-1:0] out_count_r;

  logic [CW-1:0] new_x, new_y, new_z;
  logic          new_outside;
  logic          full;
  logic          commit;

  // Magnitude of the minimum-image difference. Exactly half a box is left
  // as it stands.
  function automatic logic [MAG_W-1:0] image_mag(input logic [CW-1:0] s,
                                                 input logic [CW-1:0] c,
                                                 input logic [FIELD_W-1:0] box);
    logic signed [DW-1:0] d;
    logic signed [DW-1:0] bx;
    d  = $signed(DW'(s)) - $signed(DW'(c));
    bx = $signed(DW'(box));
    if ((d <<< 1) > bx) begin
      d = d - bx;
    end else if ((d <<< 1) < -bx) begin
      d = d + bx;
    end
    image_mag = d[DW-1] ? MAG_W'(-d) : MAG_W'(d);
  endfunction

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      box_r <= BOX_LENGTH_RST;
      min_r <= MIN_DISTANCE_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_addr)
        CFG_BOX_LENGTH:   box_r <= cfg_wdata;
        CFG_MIN_DISTANCE: min_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Latch the incoming word
  assign new_x = CW'(in_cand_x);
  assign new_y = CW'(in_cand_y);
  assign new_z = CW'(in_cand_z);
  assign new_outside = (CMP_W'(new_x) >= CMP_W'(box_r)) ||
                       (CMP_W'(new_y) >= CMP_W'(box_r)) ||
                       (CMP_W'(new_z) >= CMP_W'(box_r));

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r      <= in_op;
      cx_r      <= new_x;
      cy_r      <= new_y;
      cz_r      <= new_z;
      outside_r <= new_outside;
      limit_r   <= LIM_W'(min_r) * LIM_W'(min_r);
    end
  end

  // Scan address
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_addr_r <= '0;
    end else if (cmd.load) begin
      scan_addr_r <= '0;
    end else if (cmd.issue) begin
      scan_addr_r <= scan_addr_r + AW'(1);
    end
  end

  // Position store: one read or one write per cycle
  always_ff @(posedge clk) begin
    if (cmd.issue) begin
      rd_pos_r <= pos_mem[scan_addr_r];
    end
    if (commit) begin
      pos_mem[count_r[AW-1:0]] <= {cz_r, cy_r, cx_r};
    end
  end

  // Square stage
  assign mag_x = image_mag(rd_pos_r[CW-1:0],      cx_r, box_r);
  assign mag_y = image_mag(rd_pos_r[2*CW-1:CW],   cy_r, box_r);
  assign mag_z = image_mag(rd_pos_r[3*CW-1:2*CW], cz_r, box_r);

  always_ff @(posedge clk) begin
    if (rd_vld_r) begin
      sq_x_r <= SQ_W'(mag_x) * SQ_W'(mag_x);
      sq_y_r <= SQ_W'(mag_y) * SQ_W'(mag_y);
      sq_z_r <= SQ_W'(mag_z) * SQ_W'(mag_z);
    end
  end

  // Sum and compare stage
  assign dist_sq = SUM_W'(sq_x_r) + SUM_W'(sq_y_r) + SUM_W'(sq_z_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r <= 1'b0;
      sq_vld_r <= 1'b0;
      hit_r    <= 1'b0;
    end else if (cmd.load) begin
      rd_vld_r <= 1'b0;
      sq_vld_r <= 1'b0;
      hit_r    <= 1'b0;
    end else begin
      rd_vld_r <= cmd.issue;
      sq_vld_r <= rd_vld_r;
      if (sq_vld_r && (dist_sq < SUM_W'(limit_r))) begin
        hit_r <= 1'b1;
      end
    end
  end

  // Outcome
  assign full = (count_r == CNT_W'(MAX_PARTICLES));

  always_comb begin
    out_status_nxt = ST_OK;
    out_slot_nxt   = '0;
    count_nxt      = count_r;
    commit         = 1'b0;
    if (op_r == OP_CLEAR) begin
      count_nxt = '0;
    end else if (outside_r) begin
      out_status_nxt = ST_OUTSIDE;
    end else if (full) begin
      out_status_nxt = ST_FULL;
    end else if (hit_r) begin
      out_status_nxt = ST_OVERLAP;
    end else begin
      commit       = cmd.finish;
      out_slot_nxt = SLOT_W'(count_r);
      count_nxt    = count_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.finish) begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (cmd.finish) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_status_r <= out_status_nxt;
      out_slot_r   <= out_slot_nxt;
      out_count_r  <= OUT_CNT_W'(count_nxt);
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_status = out_status_r;
  assign out_slot   = out_slot_r;
  assign out_count  = out_count_r;

  // Status to the controller
  assign sts.quick    = (op_r == OP_CLEAR) || outside_r || full || (count_r == '0);
  assign sts.last     = ((CNT_W'(scan_addr_r) + CNT_W'(1)) == count_r);
  assign sts.busy     = rd_vld_r || sq_vld_r;
  assign sts.hit      = hit_r;
  assign sts.out_free = !out_vld_r || out_tready;

endmodule

/* dv/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for periodic_hard_sphere_insertion_top
// Candidate words go in through the input stream. Each one is run through a
// behavioural copy of the store and the minimum-image overlap test, and every
// result word is compared with the oldest outstanding prediction. The run
// covers directed corner cases first. It then works through several box and
// exclusion settings with random candidates and random back-pressure on both
// streams.
// ----------------------------------------------------------------------------
module testbench;
  import phsi_pkg::*;

  localparam int STORE_DEPTH = PHSI_MAX_PARTICLES;
  localparam int QUIET_LIMIT = 4000;
  localparam int LONG_HOLD   = 400;

  typedef struct packed {
    logic               op;
    logic [FIELD_W-1:0] x;
    logic [FIELD_W-1:0] y;
    logic [FIELD_W-1:0] z;
  } cand_word_t;

  typedef struct packed {
    logic [STATUS_W-1:0]  status;
    logic [SLOT_W-1:0]    slot;
    logic [OUT_CNT_W-1:0] count;
  } insert_outcome_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_wr_en = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr = CFG_BOX_LENGTH;
  logic [FIELD_W-1:0]    cfg_wdata = '0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [3*FIELD_W-1:0]  in_tdata = '0;   // cand_x, cand_y, cand_z
  logic                  in_tuser = 1'b0; // op
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [23:0]           out_tdata;       // slot, stored_count, zero fill
  logic [STATUS_W-1:0]   out_tuser;       // status

  // Shadow of the block's state and registers.
  logic [FIELD_W-1:0] shadow_x [STORE_DEPTH];
  logic [FIELD_W-1:0] shadow_y [STORE_DEPTH];
  logic [FIELD_W-1:0] shadow_z [STORE_DEPTH];
  int                 shadow_count = 0;
  logic [FIELD_W-1:0] box_len = BOX_LENGTH_RST;
  logic [FIELD_W-1:0] excl_dist = MIN_DISTANCE_RST;

  cand_word_t      cand_backlog [$];
  insert_outcome_t outcome_q [$];
  cand_word_t      cur_word;

  int idle_pct = 0;
  int send_gap = 0;
  int stall_left = 0;
  int hold_left = 0;
  bit long_hold_done = 1'b0;
  int outcomes_seen = 0;
  int mismatch_count = 0;
  int quiet_cycles = 0;

  periodic_hard_sphere_insertion_top u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Squared minimum-image separation along one axis. Only one box length is
  // ever taken off, so a stale position from a larger box can stay far away.
  function automatic longint image_sq(logic [FIELD_W-1:0] stored, logic [FIELD_W-1:0] cand);
    longint d;
    longint b;
    d = longint'(stored) - longint'(cand);
    b = longint'(box_len);
    if (2 * d > b) d = d - b;
    else if (2 * d < -b) d = d + b;
    return d * d;
  endfunction

  function automatic insert_outcome_t insert_outcome(cand_word_t w);
    insert_outcome_t r;
    longint limit;
    longint dist_sq;
    bit hit;
    r = '0;
    r.status = ST_OK;
    hit = 1'b0;
    limit = longint'(excl_dist) * longint'(excl_dist);
    if (w.op == OP_CLEAR) begin
      shadow_count = 0;
    end else if (w.x >= box_len || w.y >= box_len || w.z >= box_len) begin
      r.status = ST_OUTSIDE;
    end else if (shadow_count >= STORE_DEPTH) begin
      r.status = ST_FULL;
    end else begin
      for (int i = 0; i < shadow_count && !hit; i++) begin
        dist_sq = image_sq(shadow_x[i], w.x) + image_sq(shadow_y[i], w.y)
                + image_sq(shadow_z[i], w.z);
        if (dist_sq < limit) hit = 1'b1;
      end
      if (hit) begin
        r.status = ST_OVERLAP;
      end else begin
        shadow_x[shadow_count] = w.x;
        shadow_y[shadow_count] = w.y;
        shadow_z[shadow_count] = w.z;
        r.slot = shadow_count[SLOT_W-1:0];
        shadow_count++;
      end
    end
    r.count = shadow_count[OUT_CNT_W-1:0];
    return r;
  endfunction

  // Input driver: holds each word until it is taken, with short random gaps.
  always @(posedge clk) begin : driver
    cand_word_t nxt;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) outcome_q.push_back(insert_outcome(cur_word));
      if (!in_tvalid || in_tready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_tvalid <= 1'b0;
        end else if (cand_backlog.size() != 0 && idle_pct > 0 &&
                     $urandom_range(0, 99) < idle_pct) begin
          send_gap = $urandom_range(0, 2);
          in_tvalid <= 1'b0;
        end else if (cand_backlog.size() != 0) begin
          nxt = cand_backlog.pop_front();
          cur_word = nxt;
          in_tvalid <= 1'b1;
          in_tdata <= {nxt.z, nxt.y, nxt.x};
          in_tuser <= nxt.op;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Result monitor and receiver back-pressure. One long hold lets the block
  // fill up and stall its input while the driver keeps offering words.
  always @(posedge clk) begin : monitor
    insert_outcome_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        outcomes_seen++;
        if (outcome_q.size() == 0) begin
          $error("result word with nothing outstanding: status %0d", out_tuser);
          mismatch_count++;
        end else begin
          want = outcome_q.pop_front();
          if (out_tuser !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, out_tuser);
            mismatch_count++;
          end
          if (out_tdata[7:0] !== want.slot) begin
            $error("slot: expected %0d, actual %0d", want.slot, out_tdata[7:0]);
            mismatch_count++;
          end
          if (out_tdata[16:8] !== want.count) begin
            $error("stored_count: expected %0d, actual %0d", want.count, out_tdata[16:8]);
            mismatch_count++;
          end
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else if (!long_hold_done && outcomes_seen >= 100) begin
        long_hold_done = 1'b1;
        hold_left = LONG_HOLD - 1;
        out_tready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
        stall_left = $urandom_range(0, 2);
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_wr_en) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("status: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic push_word(input logic op, input logic [FIELD_W-1:0] x,
                           input logic [FIELD_W-1:0] y, input logic [FIELD_W-1:0] z);
    cand_word_t w;
    w.op = op;
    w.x = x;
    w.y = y;
    w.z = z;
    cand_backlog.push_back(w);
  endtask

  // Mostly coordinates inside the box, with the edges and some wild values.
  function automatic logic [FIELD_W-1:0] pick_coord(int box);
    int r;
    r = $urandom_range(0, 99);
    if (box == 0 || r < 4) return FIELD_W'($urandom);
    if (r < 7) return '0;
    if (r < 10) return FIELD_W'(box - 1);
    return FIELD_W'($urandom_range(0, box - 1));
  endfunction

  // Wait until every word has gone in and every result has come back.
  task automatic drain();
    do @(negedge clk);
    while (cand_backlog.size() != 0 || in_tvalid || outcome_q.size() != 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_config(input int box, input int excl);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_addr <= CFG_BOX_LENGTH;
    cfg_wdata <= FIELD_W'(box);
    @(posedge clk);
    cfg_addr <= CFG_MIN_DISTANCE;
    cfg_wdata <= FIELD_W'(excl);
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    box_len = FIELD_W'(box);
    excl_dist = FIELD_W'(excl);
  endtask

  task automatic run_phase(input int box, input int excl, input int n_words,
                           input int clear_pct, input int idle, input bit clear_first);
    drain();
    set_config(box, excl);
    @(negedge clk);
    idle_pct = idle;
    if (clear_first)
      push_word(OP_CLEAR, FIELD_W'($urandom), FIELD_W'($urandom), FIELD_W'($urandom));
    for (int k = 0; k < n_words; k++) begin
      if ($urandom_range(0, 99) < clear_pct)
        push_word(OP_CLEAR, FIELD_W'($urandom), FIELD_W'($urandom), FIELD_W'($urandom));
      else
        push_word(OP_INSERT, pick_coord(box), pick_coord(box), pick_coord(box));
    end
  endtask

  initial begin : stimulus
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    idle_pct = 20;
    // Corner cases at the reset settings: box 25998, exclusion 1.0.
    push_word(OP_CLEAR, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    push_word(OP_INSERT, 16'd0, 16'd0, 16'd0);          // empty store, no compare
    push_word(OP_INSERT, 16'd25997, 16'd0, 16'd0);      // wraps to one unit away
    push_word(OP_INSERT, 16'd0, 16'd25997, 16'd25997);
    push_word(OP_INSERT, 16'd12999, 16'd0, 16'd0);      // exactly half a box, no shift
    push_word(OP_INSERT, 16'd4095, 16'd0, 16'd0);       // just inside the exclusion
    push_word(OP_INSERT, 16'd0, 16'd4096, 16'd0);       // exactly at the exclusion
    push_word(OP_INSERT, 16'd25998, 16'd0, 16'd0);      // on the box edge is outside
    push_word(OP_INSERT, 16'd0, 16'd25998, 16'd0);
    push_word(OP_INSERT, 16'd0, 16'd0, 16'd25998);
    push_word(OP_INSERT, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    push_word(OP_INSERT, 16'd25997, 16'd25997, 16'd25997);
    push_word(OP_INSERT, 16'd20000, 16'd20000, 16'd20000);
    push_word(OP_CLEAR, 16'h5A5A, 16'hA5A5, 16'h0F0F);
    push_word(OP_INSERT, 16'd5, 16'd5, 16'd5);

    run_phase(25998, 4096, 300, 2, 25, 1'b0);
    run_phase(65535, 0, 320, 0, 0, 1'b1);        // nothing overlaps: fill the store
    run_phase(65535, 65535, 100, 2, 30, 1'b1);   // everything overlaps
    run_phase(1, 1, 60, 5, 15, 1'b1);            // smallest nonzero box
    run_phase(4096, 300, 300, 1, 20, 1'b1);
    run_phase(40000, 2000, 200, 0, 20, 1'b1);
    // Shrink the box with the old positions kept in the store.
    run_phase(20000, 2000, 200, 0, 20, 1'b0);
    run_phase(0, 4096, 20, 10, 15, 1'b0);        // zero box: all outside
    run_phase($urandom_range(8000, 65535), $urandom_range(500, 6000), 250, 2, 0, 1'b1);

    drain();
    repeat (20) @(posedge clk);
    if (mismatch_count == 0 && outcome_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

/* filelist.f */
hdl/phsi_pkg.sv
hdl/phsi_ctrl.sv
hdl/phsi_dp.sv
hdl/periodic_hard_sphere_insertion_top.sv
dv/testbench.sv
